// File: src/rsd_pkg.sv
// Shared widths, types and register codes of the ring spring-damper force block.
package rsd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int CFG_W     = 31;

    // Offset, square and root widths.
    localparam int DIFF_W = WORD_W + 1;
    localparam int MAG_W  = WORD_W;
    localparam int SQ_W   = 2 * MAG_W + 1;
    localparam int ROOT_W = (SQ_W + 1) / 2;
    localparam int RADP_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    // Direction divider: the quotient stays below 2.0.
    localparam int Q_W  = FRAC_BITS + 1;
    localparam int DR_W = ROOT_W + 1;

    // Product and sum widths of the force arithmetic.
    localparam int MX_W    = DIFF_W + Q_W;
    localparam int DOT_W   = MX_W - FRAC_BITS + 2;
    localparam int DIFF2_W = ROOT_W + 1;
    localparam int DH      = DIFF2_W / 2;
    localparam int KP_W    = CFG_W + DIFF2_W - DH;
    localparam int KT_W    = CFG_W + DIFF2_W - FRAC_BITS + 1;
    localparam int UH      = DOT_W / 2;
    localparam int UP_W    = CFG_W + DOT_W - UH;
    localparam int UT_W    = CFG_W + DOT_W - FRAC_BITS + 1;
    localparam int C_W     = UT_W + 1;
    localparam int CH      = (C_W + 1) / 2;
    localparam int CPL_W   = CH + Q_W;
    localparam int CPH_W   = C_W - CH + Q_W;
    localparam int F_W     = C_W + Q_W - FRAC_BITS + 1;
    localparam int SUM_W   = F_W + 1;

    // Stream payload widths.
    localparam int IN_W     = 12 * WORD_W;
    localparam int OUT_BITS = 2 * WORD_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_STIFFNESS = 2'd0;
    localparam t_cfg_idx CFG_REST      = 2'd1;
    localparam t_cfg_idx CFG_DAMPING   = 2'd2;

    localparam logic [CFG_W-1:0] RST_STIFFNESS = CFG_W'((1 << FRAC_BITS) / 100);
    localparam logic [CFG_W-1:0] RST_REST      = CFG_W'(100 << FRAC_BITS);
    localparam logic [CFG_W-1:0] RST_DAMPING   = CFG_W'((1 << FRAC_BITS) / 100);

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
    } t_body;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] rvx;
        logic signed [DIFF_W-1:0] rvy;
    } t_side;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        t_side             side;
        logic [Q_W-1:0]    qx;
        logic [Q_W-1:0]    qy;
    } t_dir;

endpackage

// File: src/ring_spring_damper_force_core.sv
// Top level of the ring spring-damper force block: stream ports, registers, final sum.
//
// Each input item on the slave stream carries the position and velocity of one mass
// and of its previous and next ring neighbours, all signed fixed point with FRAC_BITS
// fraction bits (Q16.16). Each item yields exactly one result item on the master
// stream: the net spring-damper force of both neighbours, saturated to 32 bits, and
// a flag set when a component was clipped.
// The block is a pipeline and takes one item in every cycle while the receiver keeps
// up. From acceptance to the result appearing on o_m_tvalid an item passes two stages
// of offsets and squares, one stage per root bit of the square root, one stage per
// quotient bit of the direction divider, seven stages of products and sums, and the
// output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_s_tready drops; nothing is lost or repeated, and a new item is taken in the same
// cycle the waiting result leaves.
// Three registers (stiffness, rest length, damping) are written over the config
// channel, which is always ready; write them only while no item is in flight.
// Synchronous reset empties the pipeline and loads the default register values.
module ring_spring_damper_force_core import rsd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Items in; fields from bit 0 up: self_pos_x, self_pos_y, self_vel_x, self_vel_y,
    // prev_pos_x, prev_pos_y, prev_vel_x, prev_vel_y,
    // next_pos_x, next_pos_y, next_vel_x, next_vel_y (32 bits each).
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,
    // Results out; fields from bit 0 up: force_x (32), force_y (32), saturated (1),
    // then zero fill.
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,
    // Register writes.
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  t_cfg_idx         i_cfg_index,
    input  logic [WORD_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_k;
    logic [CFG_W-1:0] r_rest;
    logic [CFG_W-1:0] r_u;

    assign o_cfg_ready = 1'b1;

    // Writes beyond the last register are accepted and dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= RST_STIFFNESS;
            r_rest <= RST_REST;
            r_u    <= RST_DAMPING;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STIFFNESS: r_k    <= i_cfg_data[CFG_W-1:0];
                CFG_REST:      r_rest <= i_cfg_data[CFG_W-1:0];
                CFG_DAMPING:   r_u    <= i_cfg_data[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being emptied.
    logic en;
    logic r_out_valid;

    assign en         = ~r_out_valid | i_m_tready;
    assign o_s_tready = en;

    t_body self_b, prev_b, next_b;

    always_comb begin
        self_b.pos_x = i_s_tdata[0*WORD_W +: WORD_W];
        self_b.pos_y = i_s_tdata[1*WORD_W +: WORD_W];
        self_b.vel_x = i_s_tdata[2*WORD_W +: WORD_W];
        self_b.vel_y = i_s_tdata[3*WORD_W +: WORD_W];
        prev_b.pos_x = i_s_tdata[4*WORD_W +: WORD_W];
        prev_b.pos_y = i_s_tdata[5*WORD_W +: WORD_W];
        prev_b.vel_x = i_s_tdata[6*WORD_W +: WORD_W];
        prev_b.vel_y = i_s_tdata[7*WORD_W +: WORD_W];
        next_b.pos_x = i_s_tdata[8*WORD_W +: WORD_W];
        next_b.pos_y = i_s_tdata[9*WORD_W +: WORD_W];
        next_b.vel_x = i_s_tdata[10*WORD_W +: WORD_W];
        next_b.vel_y = i_s_tdata[11*WORD_W +: WORD_W];
    end

    logic                  prev_v, next_v;
    logic signed [F_W-1:0] prev_fx, prev_fy, next_fx, next_fy;

    rsd_term u_prev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_self  (self_b),
        .i_nb    (prev_b),
        .i_k     (r_k),
        .i_rest  (r_rest),
        .i_u     (r_u),
        .o_valid (prev_v),
        .o_fx    (prev_fx),
        .o_fy    (prev_fy)
    );

    rsd_term u_next (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_tvalid),
        .i_self  (self_b),
        .i_nb    (next_b),
        .i_k     (r_k),
        .i_rest  (r_rest),
        .i_u     (r_u),
        .o_valid (next_v),
        .o_fx    (next_fx),
        .o_fy    (next_fy)
    );

    // Both neighbour pipelines run in lockstep, so their valid bits always agree.
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic                    ovf_x, ovf_y;
    logic [WORD_W-1:0]       n_fx, n_fy;
    logic [WORD_W-1:0]       r_fx, r_fy;
    logic                    r_sat;
    logic [WORD_W-1:0]       sat_pos, sat_neg;

    always_comb begin
        sat_pos = {1'b0, {(WORD_W-1){1'b1}}};
        sat_neg = {1'b1, {(WORD_W-1){1'b0}}};
        sum_x   = SUM_W'(prev_fx) + SUM_W'(next_fx);
        sum_y   = SUM_W'(prev_fy) + SUM_W'(next_fy);
        ovf_x   = ~((&sum_x[SUM_W-1:WORD_W-1]) | ~(|sum_x[SUM_W-1:WORD_W-1]));
        ovf_y   = ~((&sum_y[SUM_W-1:WORD_W-1]) | ~(|sum_y[SUM_W-1:WORD_W-1]));
        n_fx    = ovf_x ? (sum_x[SUM_W-1] ? sat_neg : sat_pos) : sum_x[WORD_W-1:0];
        n_fy    = ovf_y ? (sum_y[SUM_W-1] ? sat_neg : sat_pos) : sum_y[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= prev_v & next_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx  <= n_fx;
            r_fy  <= n_fy;
            r_sat <= ovf_x | ovf_y;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_sat, r_fy, r_fx});

endmodule

// File: src/rsd_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
module rsd_sqrt import rsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic              a_v    [0:ROOT_W];
    logic [RADP_W-1:0] a_rad  [0:ROOT_W];
    logic [ROOT_W-1:0] a_root [0:ROOT_W];
    logic [REM_W-1:0]  a_rem  [0:ROOT_W];
    t_side             a_side [0:ROOT_W];

    assign a_v[0]    = i_valid;
    assign a_rad[0]  = RADP_W'(i_rad);
    assign a_root[0] = '0;
    assign a_rem[0]  = '0;
    assign a_side[0] = i_side;

    genvar g;
    for (g = 0; g < ROOT_W; g++) begin : g_step
        logic              r_v;
        logic [RADP_W-1:0] r_rad;
        logic [ROOT_W-1:0] r_root;
        logic [REM_W-1:0]  r_rem;
        t_side             r_side;
        logic [REM_W-1:0]  n_rem;
        logic [REM_W-1:0]  n_trial;
        logic              n_bit;

        always_comb begin
            n_rem   = {a_rem[g][REM_W-3:0], a_rad[g][RADP_W-1-2*g -: 2]};
            n_trial = REM_W'({a_root[g], 2'b01});
            n_bit   = (n_rem >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= a_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= a_rad[g];
                r_side <= a_side[g];
                r_root <= {a_root[g][ROOT_W-2:0], n_bit};
                r_rem  <= n_bit ? (n_rem - n_trial) : n_rem;
            end
        end

        assign a_v[g+1]    = r_v;
        assign a_rad[g+1]  = r_rad;
        assign a_root[g+1] = r_root;
        assign a_rem[g+1]  = r_rem;
        assign a_side[g+1] = r_side;
    end

    assign o_valid = a_v[ROOT_W];
    assign o_root  = a_root[ROOT_W];
    assign o_side  = a_side[ROOT_W];

endmodule

// File: src/rsd_div.sv
// Pipelined restoring divider that forms both direction components, one bit per stage.
module rsd_div import rsd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_len,
    input  t_side             i_side,
    output logic              o_valid,
    output t_dir              o_dir
);

    logic              a_v   [0:Q_W];
    logic [ROOT_W-1:0] a_len [0:Q_W];
    t_side             a_side[0:Q_W];
    logic [MAG_W-1:0]  a_ax  [0:Q_W];
    logic [MAG_W-1:0]  a_ay  [0:Q_W];
    logic [DR_W-1:0]   a_rx  [0:Q_W];
    logic [DR_W-1:0]   a_ry  [0:Q_W];
    logic [Q_W-1:0]    a_qx  [0:Q_W];
    logic [Q_W-1:0]    a_qy  [0:Q_W];
    logic [MAG_W-1:0]  in_ax;
    logic [MAG_W-1:0]  in_ay;

    assign in_ax = MAG_W'(i_side.dx[DIFF_W-1] ? -i_side.dx : i_side.dx);
    assign in_ay = MAG_W'(i_side.dy[DIFF_W-1] ? -i_side.dy : i_side.dy);

    // The first remainder is the dividend above the quotient bits; it is below len.
    assign a_v[0]    = i_valid;
    assign a_len[0]  = i_len;
    assign a_side[0] = i_side;
    assign a_ax[0]   = in_ax;
    assign a_ay[0]   = in_ay;
    assign a_rx[0]   = DR_W'(in_ax >> 1);
    assign a_ry[0]   = DR_W'(in_ay >> 1);
    assign a_qx[0]   = '0;
    assign a_qy[0]   = '0;

    genvar g;
    for (g = 0; g < Q_W; g++) begin : g_step
        localparam int J = Q_W - 1 - g;
        logic              r_v;
        logic [ROOT_W-1:0] r_len;
        t_side             r_side;
        logic [MAG_W-1:0]  r_ax;
        logic [MAG_W-1:0]  r_ay;
        logic [DR_W-1:0]   r_rx;
        logic [DR_W-1:0]   r_ry;
        logic [Q_W-1:0]    r_qx;
        logic [Q_W-1:0]    r_qy;
        logic [MAG_W+FRAC_BITS-1:0] n_numx;
        logic [MAG_W+FRAC_BITS-1:0] n_numy;
        logic [DR_W:0]     n_sx;
        logic [DR_W:0]     n_sy;
        logic [DR_W:0]     n_l;
        logic              n_bx;
        logic              n_by;

        always_comb begin
            n_numx = {a_ax[g], {FRAC_BITS{1'b0}}};
            n_numy = {a_ay[g], {FRAC_BITS{1'b0}}};
            n_sx   = {a_rx[g], n_numx[J]};
            n_sy   = {a_ry[g], n_numy[J]};
            n_l    = (DR_W+1)'(a_len[g]);
            n_bx   = (n_sx >= n_l);
            n_by   = (n_sy >= n_l);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= a_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len  <= a_len[g];
                r_side <= a_side[g];
                r_ax   <= a_ax[g];
                r_ay   <= a_ay[g];
                r_rx   <= DR_W'(n_bx ? (n_sx - n_l) : n_sx);
                r_ry   <= DR_W'(n_by ? (n_sy - n_l) : n_sy);
                r_qx   <= {a_qx[g][Q_W-2:0], n_bx};
                r_qy   <= {a_qy[g][Q_W-2:0], n_by};
            end
        end

        assign a_v[g+1]    = r_v;
        assign a_len[g+1]  = r_len;
        assign a_side[g+1] = r_side;
        assign a_ax[g+1]   = r_ax;
        assign a_ay[g+1]   = r_ay;
        assign a_rx[g+1]   = r_rx;
        assign a_ry[g+1]   = r_ry;
        assign a_qx[g+1]   = r_qx;
        assign a_qy[g+1]   = r_qy;
    end

    // A zero-length offset has no direction.
    always_comb begin
        o_dir.len  = a_len[Q_W];
        o_dir.side = a_side[Q_W];
        o_dir.qx   = (a_len[Q_W] == '0) ? '0 : a_qx[Q_W];
        o_dir.qy   = (a_len[Q_W] == '0) ? '0 : a_qy[Q_W];
    end
    assign o_valid = a_v[Q_W];

endmodule

// File: src/rsd_term.sv
// Force of one ring neighbour on the mass: offset, length, direction and spring-damper term.
module rsd_term import rsd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_body                  i_self,
    input  t_body                  i_nb,
    input  logic [CFG_W-1:0]       i_k,
    input  logic [CFG_W-1:0]       i_rest,
    input  logic [CFG_W-1:0]       i_u,
    output logic                   o_valid,
    output logic signed [F_W-1:0]  o_fx,
    output logic signed [F_W-1:0]  o_fy
);

    // Stage 1: offsets and relative velocities.
    logic r1_v;
    t_side n1_side, r1_side;

    always_comb begin
        n1_side.dx  = DIFF_W'(i_self.pos_x) - DIFF_W'(i_nb.pos_x);
        n1_side.dy  = DIFF_W'(i_self.pos_y) - DIFF_W'(i_nb.pos_y);
        n1_side.rvx = DIFF_W'(i_self.vel_x) - DIFF_W'(i_nb.vel_x);
        n1_side.rvy = DIFF_W'(i_self.vel_y) - DIFF_W'(i_nb.vel_y);
    end

    // Stage 2: sum of squares.
    logic r2_v;
    t_side r2_side;
    logic [MAG_W-1:0]   n2_ax, n2_ay;
    logic [2*MAG_W-1:0] n2_s1, n2_s2;
    logic [SQ_W-1:0]    n2_sq, r2_sq;

    always_comb begin
        n2_ax = MAG_W'(r1_side.dx[DIFF_W-1] ? -r1_side.dx : r1_side.dx);
        n2_ay = MAG_W'(r1_side.dy[DIFF_W-1] ? -r1_side.dy : r1_side.dy);
        n2_s1 = n2_ax * n2_ax;
        n2_s2 = n2_ay * n2_ay;
        n2_sq = {1'b0, n2_s1} + {1'b0, n2_s2};
    end

    logic              sq_v;
    logic [ROOT_W-1:0] sq_len;
    t_side             sq_side;

    rsd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r2_v),
        .i_rad   (r2_sq),
        .i_side  (r2_side),
        .o_valid (sq_v),
        .o_root  (sq_len),
        .o_side  (sq_side)
    );

    logic dv_v;
    t_dir dv;

    rsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (sq_v),
        .i_len   (sq_len),
        .i_side  (sq_side),
        .o_valid (dv_v),
        .o_dir   (dv)
    );

    // Stage 3: velocity products along the direction, length error.
    logic r3_v;
    logic [DIFF_W-1:0] n3_arx, n3_ary;
    logic [MX_W-1:0]   n3_mx, n3_my, r3_mx, r3_my;
    logic signed [DIFF2_W-1:0] n3_diff, r3_diff;
    logic r3_sx, r3_sy, r3_dxn, r3_dyn;
    logic [Q_W-1:0] r3_qx, r3_qy;

    always_comb begin
        n3_arx  = dv.side.rvx[DIFF_W-1] ? -dv.side.rvx : dv.side.rvx;
        n3_ary  = dv.side.rvy[DIFF_W-1] ? -dv.side.rvy : dv.side.rvy;
        n3_mx   = n3_arx * dv.qx;
        n3_my   = n3_ary * dv.qy;
        n3_diff = $signed(DIFF2_W'(i_rest)) - $signed(DIFF2_W'(dv.len));
    end

    // Stage 4: dot product, spring partial products.
    logic r4_v;
    logic signed [DOT_W-1:0] n4_px, n4_py, n4_dot, r4_dot;
    logic [DIFF2_W-1:0] n4_ad;
    logic [KP_W-1:0] n4_kl, n4_kh, r4_kl, r4_kh;
    logic r4_ks, r4_dxn, r4_dyn;
    logic [Q_W-1:0] r4_qx, r4_qy;

    always_comb begin
        n4_px  = $signed(DOT_W'(r3_mx[MX_W-1:FRAC_BITS]));
        n4_py  = $signed(DOT_W'(r3_my[MX_W-1:FRAC_BITS]));
        if (r3_sx) begin
            n4_px = -n4_px;
        end
        if (r3_sy) begin
            n4_py = -n4_py;
        end
        n4_dot = n4_px + n4_py;
        n4_ad  = r3_diff[DIFF2_W-1] ? -r3_diff : r3_diff;
        n4_kl  = i_k * n4_ad[DH-1:0];
        n4_kh  = i_k * n4_ad[DIFF2_W-1:DH];
    end

    // Stage 5: spring term, damping partial products.
    logic r5_v;
    logic [CFG_W+DIFF2_W-1:0] n5_kf;
    logic signed [KT_W-1:0] n5_kt, r5_kt;
    logic [DOT_W-1:0] n5_ad;
    logic [UP_W-1:0] n5_ul, n5_uh, r5_ul, r5_uh;
    logic r5_us, r5_dxn, r5_dyn;
    logic [Q_W-1:0] r5_qx, r5_qy;

    always_comb begin
        n5_kf = {r4_kh, {DH{1'b0}}} + (CFG_W+DIFF2_W)'(r4_kl);
        n5_kt = $signed(KT_W'(n5_kf[CFG_W+DIFF2_W-1:FRAC_BITS]));
        if (r4_ks) begin
            n5_kt = -n5_kt;
        end
        n5_ad = r4_dot[DOT_W-1] ? -r4_dot : r4_dot;
        n5_ul = i_u * n5_ad[UH-1:0];
        n5_uh = i_u * n5_ad[DOT_W-1:UH];
    end

    // Stage 6: damping term, which opposes the closing speed.
    logic r6_v;
    logic [CFG_W+DOT_W-1:0] n6_uf;
    logic signed [UT_W-1:0] n6_ut, r6_ut;
    logic signed [KT_W-1:0] r6_kt;
    logic r6_dxn, r6_dyn;
    logic [Q_W-1:0] r6_qx, r6_qy;

    always_comb begin
        n6_uf = {r5_uh, {UH{1'b0}}} + (CFG_W+DOT_W)'(r5_ul);
        n6_ut = $signed(UT_W'(n6_uf[CFG_W+DOT_W-1:FRAC_BITS]));
        if (r5_us) begin
            n6_ut = -n6_ut;
        end
    end

    // Stage 7: scalar force along the spring.
    logic r7_v;
    logic signed [C_W-1:0] n7_c, r7_c;
    logic r7_dxn, r7_dyn;
    logic [Q_W-1:0] r7_qx, r7_qy;

    assign n7_c = C_W'(r6_kt) + C_W'(r6_ut);

    // Stage 8: partial products of the scalar with the direction.
    logic r8_v;
    logic [C_W-1:0] n8_ac;
    logic [CPL_W-1:0] n8_xl, n8_yl, r8_xl, r8_yl;
    logic [CPH_W-1:0] n8_xh, n8_yh, r8_xh, r8_yh;
    logic r8_sx, r8_sy;

    always_comb begin
        n8_ac = r7_c[C_W-1] ? -r7_c : r7_c;
        n8_xl = n8_ac[CH-1:0] * r7_qx;
        n8_yl = n8_ac[CH-1:0] * r7_qy;
        n8_xh = n8_ac[C_W-1:CH] * r7_qx;
        n8_yh = n8_ac[C_W-1:CH] * r7_qy;
    end

    // Stage 9: force components.
    logic r9_v;
    logic [C_W+Q_W-1:0] n9_fxf, n9_fyf;
    logic signed [F_W-1:0] n9_fx, n9_fy, r9_fx, r9_fy;

    always_comb begin
        n9_fxf = {r8_xh, {CH{1'b0}}} + (C_W+Q_W)'(r8_xl);
        n9_fyf = {r8_yh, {CH{1'b0}}} + (C_W+Q_W)'(r8_yl);
        n9_fx  = $signed(F_W'(n9_fxf[C_W+Q_W-1:FRAC_BITS]));
        n9_fy  = $signed(F_W'(n9_fyf[C_W+Q_W-1:FRAC_BITS]));
        if (r8_sx) begin
            n9_fx = -n9_fx;
        end
        if (r8_sy) begin
            n9_fy = -n9_fy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= dv_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side <= n1_side;
            r2_side <= r1_side;
            r2_sq   <= n2_sq;
            r3_mx   <= n3_mx;
            r3_my   <= n3_my;
            r3_diff <= n3_diff;
            r3_sx   <= dv.side.rvx[DIFF_W-1] ^ dv.side.dx[DIFF_W-1];
            r3_sy   <= dv.side.rvy[DIFF_W-1] ^ dv.side.dy[DIFF_W-1];
            r3_dxn  <= dv.side.dx[DIFF_W-1];
            r3_dyn  <= dv.side.dy[DIFF_W-1];
            r3_qx   <= dv.qx;
            r3_qy   <= dv.qy;
            r4_dot  <= n4_dot;
            r4_kl   <= n4_kl;
            r4_kh   <= n4_kh;
            r4_ks   <= r3_diff[DIFF2_W-1];
            r4_dxn  <= r3_dxn;
            r4_dyn  <= r3_dyn;
            r4_qx   <= r3_qx;
            r4_qy   <= r3_qy;
            r5_kt   <= n5_kt;
            r5_ul   <= n5_ul;
            r5_uh   <= n5_uh;
            r5_us   <= ~r4_dot[DOT_W-1];
            r5_dxn  <= r4_dxn;
            r5_dyn  <= r4_dyn;
            r5_qx   <= r4_qx;
            r5_qy   <= r4_qy;
            r6_ut   <= n6_ut;
            r6_kt   <= r5_kt;
            r6_dxn  <= r5_dxn;
            r6_dyn  <= r5_dyn;
            r6_qx   <= r5_qx;
            r6_qy   <= r5_qy;
            r7_c    <= n7_c;
            r7_dxn  <= r6_dxn;
            r7_dyn  <= r6_dyn;
            r7_qx   <= r6_qx;
            r7_qy   <= r6_qy;
            r8_xl   <= n8_xl;
            r8_yl   <= n8_yl;
            r8_xh   <= n8_xh;
            r8_yh   <= n8_yh;
            r8_sx   <= r7_c[C_W-1] ^ r7_dxn;
            r8_sy   <= r7_c[C_W-1] ^ r7_dyn;
            r9_fx   <= n9_fx;
            r9_fy   <= n9_fy;
        end
    end

    assign o_valid = r9_v;
    assign o_fx    = r9_fx;
    assign o_fy    = r9_fy;

endmodule
